// File: rtl/core/assert_macros.svh
// assertion macros shared by the record sorter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RSBK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define RSBK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/rsbk_pkg.sv
// shared types and constants of the record sorter
package rsbk_pkg;

  localparam int KEY_W     = 32;
  localparam int TAG_W     = 6;
  localparam int DEPTH_DEF = 64;

  // input request
  typedef struct packed {
    logic [KEY_W-1:0] key_in;
    logic [TAG_W-1:0] tag_in;
    logic             load_last;
  } in_req_t;

  // result request
  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    logic [TAG_W-1:0] tag_out;
    logic             out_last;
  } out_req_t;

  // one stored record
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

endpackage

// File: rtl/core/rsbk_rec_ram.sv
// record store: one write port, one read port with registered read data
module rsbk_rec_ram
  import rsbk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rec_t                     wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rec_t                     rd_data
);

  rec_t mem [DEPTH];
  rec_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/record_sort_by_key_descending_unit.sv
// top level of the record sorter: load, exchange sort, sorted output
//
//   channel | ports                          | moves
//   --------+--------------------------------+------------------------------------
//   input   | in_valid, in_stall, in_data    | one record, load_last closes the set
//   output  | out_valid, out_stall, out_data | sorted records, out_last on final
//
// Loading takes one request per cycle while in_stall is low. After the request
// marked last, the sort compares one key pair at a time through the single
// read port of the record store, then the output sweep reads and presents
// each record in turn, holding while out_stall holds.
// in_stall is high from the last request until the final result is registered.
// Reset (rst_n low, synchronous) empties the set and drops any pending result.
`include "assert_macros.svh"

module record_sort_by_key_descending_unit
  import rsbk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDI,
    S_GETI,
    S_RDJ,
    S_CMP,
    S_WRI,
    S_ORD,
    S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  rec_t            cur_r, cur_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_req_t        out_r, out_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  rec_t            rd_data;

  logic [CW-1:0]   phys_i;
  logic [CW-1:0]   phys_j;
  logic            key_less;
  logic            out_free;

  logic            cmp_idx_ok;
  logic            last_taken;
  logic            run_closed;
  logic            is_quiet;

  // records are stored in arrival order; sorted position p sits at count-1-p
  assign phys_i   = count_r - ONE_C - i_r;
  assign phys_j   = count_r - ONE_C - j_r;
  // the one shared key comparator
  assign key_less = cur_r.key < rd_data.key;
  assign out_free = !out_valid_r || !out_stall;

  rsbk_rec_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer: load, then i/j exchange passes, then output sweep
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = phys_i[AW-1:0];
    wr_data       = cur_r;
    rd_en         = 1'b0;
    rd_addr       = phys_i[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // store unless the set is full
          if (count_r < DEPTH_C) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[AW-1:0];
            wr_data   = '{key: in_data.key_in, tag: in_data.tag_in};
            count_nxt = count_r + ONE_C;
          end
          if (in_data.load_last) begin
            i_nxt     = '0;
            state_nxt = S_RDI;
          end
        end
      end
      S_RDI: begin
        rd_en     = 1'b1;
        state_nxt = S_GETI;
      end
      S_GETI: begin
        cur_nxt = rd_data;
        if (i_r + ONE_C == count_r) begin
          // last position needs no pass
          i_nxt     = '0;
          state_nxt = S_ORD;
        end else begin
          j_nxt     = i_r + ONE_C;
          state_nxt = S_RDJ;
        end
      end
      S_RDJ: begin
        rd_en     = 1'b1;
        rd_addr   = phys_j[AW-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // swap: old holder of i goes to j, j becomes the new holder
        if (key_less) begin
          wr_en   = 1'b1;
          wr_addr = phys_j[AW-1:0];
          wr_data = cur_r;
          cur_nxt = rd_data;
        end
        if (j_r + ONE_C == count_r) begin
          state_nxt = S_WRI;
        end else begin
          j_nxt     = j_r + ONE_C;
          state_nxt = S_RDJ;
        end
      end
      S_WRI: begin
        wr_en     = 1'b1;
        i_nxt     = i_r + ONE_C;
        state_nxt = S_RDI;
      end
      S_ORD: begin
        rd_en     = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{key_out:  rd_data.key,
                            tag_out:  rd_data.tag,
                            out_last: (i_r + ONE_C == count_r)};
          if (i_r + ONE_C == count_r) begin
            count_nxt = '0;
            i_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + ONE_C;
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // terms for the checks
  assign cmp_idx_ok = (j_r > i_r) && (j_r < count_r);
  assign last_taken = (state_r == S_OUT) && out_free && (i_r + ONE_C == count_r);
  assign run_closed = out_valid_r && out_r.out_last && (state_r == S_IDLE) && (count_r == '0);
  assign is_quiet   = !out_valid_r && (state_r == S_IDLE);

  // checks
  `RSBK_ASSERT(a_count_bound, count_r <= DEPTH_C, "record count beyond depth")
  `RSBK_ASSERT(a_cmp_order, (state_r == S_CMP) |-> cmp_idx_ok, "compare index out of order")
  `RSBK_ASSERT(a_last_ends_run, last_taken |=> run_closed, "final result did not close the run")
  `RSBK_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> is_quiet, "reset left a result pending")

endmodule

// File: test/sorted_run_checker.sv
// result checker for the record sorter: predicts every sorted run and compares it
module sorted_run_checker
  import rsbk_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_req_t out_data,
  output int       fail_count,
  output int       results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAP   = DEPTH_DEF;
  localparam int PRINT_CAP = 40;

  // records loaded so far, newest at the front
  rec_t     held_records[$];
  // sorted records still to come out, oldest first
  out_req_t sorted_due[$];

  // one line per mismatch, quiet after a while but still counting
  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("[%0t] sorter mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  // load one request; a closing request sorts the set and queues the run
  task automatic store_record(input in_req_t req);
    rec_t     run[$];
    rec_t     swap_tmp;
    out_req_t res;
    if (held_records.size() < SET_CAP) begin
      held_records.push_front({req.key_in, req.tag_in});
    end
    if (req.load_last) begin
      run = held_records;
      // exchange sort, descending; ties end up wherever the swaps leave them
      for (int i = 0; i < run.size(); i++) begin
        for (int j = i + 1; j < run.size(); j++) begin
          if (run[i].key < run[j].key) begin
            swap_tmp = run[i];
            run[i]   = run[j];
            run[j]   = swap_tmp;
          end
        end
      end
      foreach (run[k]) begin
        res.key_out  = run[k].key;
        res.tag_out  = run[k].tag;
        res.out_last = (k == run.size() - 1);
        sorted_due.push_back(res);
      end
      held_records.delete();
    end
  endtask

  // compare one result request with the oldest prediction
  task automatic check_result(input out_req_t got);
    out_req_t want;
    if (sorted_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result key %h tag %0d last %0b",
                                got.key_out, got.tag_out, got.out_last));
    end else begin
      want = sorted_due.pop_front();
      if (got.key_out !== want.key_out) begin
        report_mismatch($sformatf("key %h, expected %h", got.key_out, want.key_out));
      end
      if (got.tag_out !== want.tag_out) begin
        report_mismatch($sformatf("tag %0d, expected %0d (key %h)",
                                  got.tag_out, want.tag_out, want.key_out));
      end
      if (got.out_last !== want.out_last) begin
        report_mismatch($sformatf("last flag %b, expected %b (key %h)",
                                  got.out_last, want.out_last, want.key_out));
      end
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) store_record(in_data);
    end
    results_due = sorted_due.size();
  end

endmodule

// File: test/tb.sv
// testbench top for the record sorter: clock, reset, stimulus, pacing and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsbk_pkg::*;

  localparam int SET_CAP       = DEPTH_DEF;
  localparam int RANDOM_REQS   = 310;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 100;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;
  int       fail_count;
  int       results_due;
  int       cycle_count = 0;
  int       burst_left  = 0;
  bit       steady      = 1'b0;
  int       sent        = 0;

  always #5ns clk = ~clk;

  record_sort_by_key_descending_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sorted_run_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** record_sort_by_key_descending_unit: FAILED **");
      $finish;
    end
  end

  // result-side back-pressure, cycling through a few moods
  always @(negedge clk) begin
    case ((cycle_count / 256) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((cycle_count % 5) < 2);
      default: out_stall <= ($urandom_range(0, 9) < 6);
    endcase
  end

  // present one request and hold it until taken
  task automatic push_request(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                              input bit last);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= {key, tag, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic go_quiet(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // hold off until every predicted result has come out
  task automatic drain_results();
    go_quiet(1);
    while (results_due != 0) @(negedge clk);
  endtask

  // bursts of requests with random gaps, unless in a steady stretch
  task automatic paced_request(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input bit last);
    if (!steady && burst_left == 0) begin
      go_quiet($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    push_request(key, tag, last);
  endtask

  // keys from a mix of spreads, small ranges give plenty of ties
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(input int size);
    for (int k = 0; k < size; k++) begin
      paced_request(pick_key(), TAG_W'($urandom_range(0, 63)), k == size - 1);
    end
  endtask

  initial begin
    int size;
    int goal;
    int set_no;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // single-record sets at the field extremes
    push_request(32'h0000_0000, 6'd0, 1'b1);
    drain_results();
    push_request(32'hFFFF_FFFF, 6'd63, 1'b1);
    drain_results();

    // equal keys: tie order from the exchange loop
    push_request(32'd5, 6'd1, 1'b0);
    push_request(32'd5, 6'd2, 1'b0);
    push_request(32'd5, 6'd3, 1'b0);
    push_request(32'd5, 6'd4, 1'b1);
    drain_results();

    // extremes and sign-bit boundary in one set
    push_request(32'h0000_0000, 6'd10, 1'b0);
    push_request(32'hFFFF_FFFF, 6'd11, 1'b0);
    push_request(32'h0000_0001, 6'd12, 1'b0);
    push_request(32'h8000_0000, 6'd13, 1'b0);
    push_request(32'h7FFF_FFFF, 6'd14, 1'b0);
    push_request(32'hFFFF_FFFE, 6'd15, 1'b1);
    drain_results();

    // ascending arrivals, then descending with a tie, back to back
    push_request(32'd1, 6'd21, 1'b0);
    push_request(32'd2, 6'd22, 1'b0);
    push_request(32'd3, 6'd23, 1'b0);
    push_request(32'd4, 6'd24, 1'b1);
    push_request(32'd9, 6'd31, 1'b0);
    push_request(32'd7, 6'd32, 1'b0);
    push_request(32'd7, 6'd33, 1'b0);
    push_request(32'd5, 6'd34, 1'b1);
    drain_results();

    // random sets, a few of them filling or overflowing the store
    goal   = sent + RANDOM_REQS;
    set_no = 0;
    while (sent < goal) begin
      case (set_no)
        2: size = SET_CAP;
        5: size = SET_CAP + 1;
        9: size = SET_CAP + $urandom_range(2, 6);
        default: size = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                    : $urandom_range(1, 10);
      endcase
      steady = ($urandom_range(0, 4) == 0);
      send_set(size);
      if (set_no % 6 == 3) drain_results();
      set_no++;
    end

    // wind down and give the verdict
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("** record_sort_by_key_descending_unit: PASSED **");
    end else begin
      $display("** record_sort_by_key_descending_unit: FAILED **");
    end
    $finish;
  end

endmodule
